### src/triangle_wave_channel_assert.svh
// Assertion macros for the triangle wave channel.
// Needs clk_i and rst_ni in the scope where they are used.
`ifndef TRIANGLE_WAVE_CHANNEL_ASSERT_SVH
`define TRIANGLE_WAVE_CHANNEL_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define TWC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("triangle channel check failed in the same cycle");

// Check that a condition implies a consequence in the next cycle.
`define TWC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("triangle channel check failed one cycle later");

`endif

### src/twc_pkg.sv
// Shared types, codes and lookup functions for the triangle wave channel.
// No dependencies.
package twc_pkg;

  typedef enum logic [2:0] {
    OpRegWrite    = 3'd0,
    OpStatusWrite = 3'd1,
    OpTimerTick   = 3'd2,
    OpQuarter     = 3'd3,
    OpHalf        = 3'd4
  } operation_e;

  // Channel register addresses (low two bits); address one is unused.
  localparam logic [1:0] RegControl  = 2'd0;
  localparam logic [1:0] RegPeriodLo = 2'd2;
  localparam logic [1:0] RegPeriodHi = 2'd3;

  localparam int unsigned OpWidth     = 3;
  localparam int unsigned IndexWidth  = 2;
  localparam int unsigned DataWidth   = 8;
  localparam int unsigned LevelWidth  = 4;
  localparam int unsigned PeriodWidth = 11;
  localparam int unsigned StepWidth   = 5;
  localparam int unsigned LengthWidth = 8;
  localparam int unsigned LinearWidth = 7;

  typedef logic [LengthWidth-1:0] length_t;
  typedef logic [LevelWidth-1:0]  level_t;

  // Length counter load values, indexed by the top five bits of the write.
  function automatic length_t length_lookup(input logic [4:0] idx);
    length_t val;
    case (idx)
      5'd0:  val = 8'd10;
      5'd1:  val = 8'd254;
      5'd2:  val = 8'd20;
      5'd3:  val = 8'd2;
      5'd4:  val = 8'd40;
      5'd5:  val = 8'd4;
      5'd6:  val = 8'd80;
      5'd7:  val = 8'd6;
      5'd8:  val = 8'd160;
      5'd9:  val = 8'd8;
      5'd10: val = 8'd60;
      5'd11: val = 8'd10;
      5'd12: val = 8'd14;
      5'd13: val = 8'd12;
      5'd14: val = 8'd26;
      5'd15: val = 8'd14;
      5'd16: val = 8'd12;
      5'd17: val = 8'd16;
      5'd18: val = 8'd24;
      5'd19: val = 8'd18;
      5'd20: val = 8'd48;
      5'd21: val = 8'd20;
      5'd22: val = 8'd96;
      5'd23: val = 8'd22;
      5'd24: val = 8'd192;
      5'd25: val = 8'd24;
      5'd26: val = 8'd72;
      5'd27: val = 8'd26;
      5'd28: val = 8'd16;
      5'd29: val = 8'd28;
      5'd30: val = 8'd32;
      default: val = 8'd30;
    endcase
    return val;
  endfunction

  // Triangle shape: 15 down to 0 over the first half, 0 up to 15 over the second.
  function automatic level_t wave_lookup(input logic [StepWidth-1:0] step);
    level_t val;
    if (step[4]) begin
      val = step[3:0];
    end else begin
      val = ~step[3:0];
    end
    return val;
  endfunction

endpackage

### src/twc_in_if.sv
// Input channel of the triangle wave channel: valid/ready plus one operation item.
// Depends on twc_pkg for field widths.
interface twc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [twc_pkg::OpWidth-1:0]          operation;
  logic [twc_pkg::IndexWidth-1:0]       reg_index;
  logic [twc_pkg::DataWidth-1:0]        write_data;

  modport source (output valid, output operation, output reg_index, output write_data,
                  input ready);
  modport sink   (input valid, input operation, input reg_index, input write_data,
                  output ready);
endinterface

### src/twc_out_if.sv
// Output channel of the triangle wave channel: valid/ready plus one result item.
// Depends on twc_pkg for field widths.
interface twc_out_if;
  logic                             valid;
  logic                             ready;
  logic [twc_pkg::LevelWidth-1:0]   level;
  logic                             length_active;

  modport source (output valid, output level, output length_active, input ready);
  modport sink   (input valid, input level, input length_active, output ready);
endinterface

### src/triangle_wave_channel.sv
// An accepted item fills the input register and then moves on to the result
// register; it waits in the input register while the output is stalled.
// Throughput: one item per cycle; the input register refills in the cycle the
// result register takes its item, so only a stalled output holds back input.
// Reset: asynchronous, active low; all channel state clears to zero and both
// stages come up empty.
module triangle_wave_channel (
  input  logic      clk_i,
  input  logic      rst_ni,
  twc_in_if.sink    in_i,
  twc_out_if.source out_o
);

  `include "triangle_wave_channel_assert.svh"

  // Input stage
  logic                               in_valid_q;
  logic [twc_pkg::OpWidth-1:0]        op_q;
  logic [twc_pkg::IndexWidth-1:0]     index_q;
  logic [twc_pkg::DataWidth-1:0]      data_q;

  // Channel state
  logic [twc_pkg::PeriodWidth-1:0]    period_q, period_d;
  logic [twc_pkg::PeriodWidth-1:0]    countdown_q, countdown_d;
  logic [twc_pkg::StepWidth-1:0]      step_q, step_d;
  logic [twc_pkg::LengthWidth-1:0]    length_q, length_d;
  logic [twc_pkg::LinearWidth-1:0]    linear_q, linear_d;
  logic [twc_pkg::LinearWidth-1:0]    reload_val_q, reload_val_d;
  logic                               halt_q, halt_d;
  logic                               reload_q, reload_d;
  logic                               enabled_q, enabled_d;

  // Result stage
  logic                               out_valid_q;
  logic [twc_pkg::LevelWidth-1:0]     level_q, level_d;
  logic                               active_q, active_d;

  logic advance;
  logic in_ready;

  assign advance  = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !in_valid_q || advance;

  assign in_i.ready          = in_ready;
  assign out_o.valid         = out_valid_q;
  assign out_o.level         = level_q;
  assign out_o.length_active = active_q;

  // Capture an item into the input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      op_q    <= in_i.operation;
      index_q <= in_i.reg_index;
      data_q  <= in_i.write_data;
    end
  end

  // Apply one operation to the channel state
  always_comb begin
    period_d     = period_q;
    countdown_d  = countdown_q;
    step_d       = step_q;
    length_d     = length_q;
    linear_d     = linear_q;
    reload_val_d = reload_val_q;
    halt_d       = halt_q;
    reload_d     = reload_q;
    enabled_d    = enabled_q;

    case (twc_pkg::operation_e'(op_q))
      twc_pkg::OpRegWrite: begin
        case (index_q)
          twc_pkg::RegControl: begin
            halt_d       = data_q[7];
            reload_val_d = data_q[6:0];
          end
          twc_pkg::RegPeriodLo: begin
            period_d = {period_q[10:8], data_q};
          end
          twc_pkg::RegPeriodHi: begin
            period_d = {data_q[2:0], period_q[7:0]};
            if (enabled_q) begin
              length_d = twc_pkg::length_lookup(data_q[7:3]);
            end
            reload_d = 1'b1;
          end
          default: begin
          end
        endcase
      end
      twc_pkg::OpStatusWrite: begin
        enabled_d = data_q[2];
        if (!data_q[2]) begin
          length_d = '0;
        end
      end
      twc_pkg::OpTimerTick: begin
        if (countdown_q == '0) begin
          countdown_d = period_q;
          if (length_q != '0 && linear_q != '0) begin
            step_d = step_q + 1'b1;
          end
        end else begin
          countdown_d = countdown_q - 1'b1;
        end
      end
      twc_pkg::OpQuarter, twc_pkg::OpHalf: begin
        // Linear counter first; a half frame also clocks the length counter
        if (reload_q) begin
          linear_d = reload_val_q;
        end else if (linear_q != '0) begin
          linear_d = linear_q - 1'b1;
        end
        if (!halt_q) begin
          reload_d = 1'b0;
        end
        if (op_q == twc_pkg::OpHalf && !halt_q && length_q != '0) begin
          length_d = length_q - 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Silence the output unless enabled and both counters run
    if (!enabled_d || length_d == '0 || linear_d == '0) begin
      level_d = '0;
    end else begin
      level_d = twc_pkg::wave_lookup(step_d);
    end
    active_d = (length_d != '0);
  end

  // Commit state when the item moves to the result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q     <= '0;
      countdown_q  <= '0;
      step_q       <= '0;
      length_q     <= '0;
      linear_q     <= '0;
      reload_val_q <= '0;
      halt_q       <= 1'b0;
      reload_q     <= 1'b0;
      enabled_q    <= 1'b0;
    end else if (advance) begin
      period_q     <= period_d;
      countdown_q  <= countdown_d;
      step_q       <= step_d;
      length_q     <= length_d;
      linear_q     <= linear_d;
      reload_val_q <= reload_val_d;
      halt_q       <= halt_d;
      reload_q     <= reload_d;
      enabled_q    <= enabled_d;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      level_q  <= level_d;
      active_q <= active_d;
    end
  end

  // A sounding level needs a live length counter
  `TWC_ASSERT_NOW(a_level_needs_length, out_valid_q && level_q != '0, active_q)
  // The sequencer only steps while both counters are nonzero
  `TWC_ASSERT_NEXT(a_step_frozen, length_q == '0 || linear_q == '0, $stable(step_q))
  // Disabling the channel clears the length counter
  `TWC_ASSERT_NEXT(a_disable_clears,
                   advance && op_q == twc_pkg::OpStatusWrite && !data_q[2], length_q == '0)
  // An empty result stage never blocks input
  `TWC_ASSERT_NOW(a_ready_when_free, !out_valid_q, in_ready)

endmodule
